/* design/bfa_pkg.sv */
package bfa_pkg;

  // Fixed field widths
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned SIZE_W  = 13;

  // Storage word geometry
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  // Reach of the entry index, and default store size
  localparam int unsigned INDEX_REACH     = 4096;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;

  // Size register after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  // Request codes
  typedef enum logic [1:0] {
    KIND_MARK_USED = 2'd0,
    KIND_MARK_FREE = 2'd1,
    KIND_FIND      = 2'd2,
    KIND_TEST      = 2'd3
  } kind_e;

  // Outcome of searching one word for a free entry
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
  } search_t;

  // Encode a one-hot word into the position of its set bit
  function automatic logic [BIT_W-1:0] onehot_to_idx(input logic [WORD_W-1:0] oh);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (((b >> k) & 1) == 1) begin
          idx[k] = idx[k] | oh[b];
        end
      end
    end
    return idx;
  endfunction

endpackage

/* design/bfa_bitmap_ram.sv */
module bfa_bitmap_ram #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [ADDR_W-1:0]               rd_addr_i,
  output logic [bfa_pkg::WORD_W-1:0]      rd_data_o,
  input  logic                            wr_en_i,
  input  logic [ADDR_W-1:0]               wr_addr_i,
  input  logic [bfa_pkg::WORD_W-1:0]      wr_data_i
);

  logic [bfa_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [bfa_pkg::WORD_W-1:0] rd_data_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/bfa_word_search.sv */
module bfa_word_search (
  input  logic [bfa_pkg::WORD_W-1:0] word_i,
  input  logic [bfa_pkg::SIZE_W-1:0] base_i,
  input  logic [bfa_pkg::SIZE_W-1:0] size_i,
  output bfa_pkg::search_t           result_o
);

  logic [bfa_pkg::SIZE_W:0]   word_end;
  logic [bfa_pkg::SIZE_W-1:0] remain;
  logic [bfa_pkg::WORD_W-1:0] valid_mask;
  logic [bfa_pkg::WORD_W-1:0] free_bits;
  logic [bfa_pkg::WORD_W-1:0] lowest;

  // Mask off entries at or past the managed size
  always_comb begin
    word_end = {1'b0, base_i} + (bfa_pkg::SIZE_W+1)'(bfa_pkg::WORD_W);
    remain   = size_i - base_i;
    if ({1'b0, size_i} >= word_end) begin
      valid_mask = '1;
    end else begin
      valid_mask = (bfa_pkg::WORD_W'(1) << remain[bfa_pkg::BIT_W-1:0]) - bfa_pkg::WORD_W'(1);
    end
  end

  // Isolate the lowest free bit and encode it
  assign free_bits = ~word_i & valid_mask;
  assign lowest    = free_bits & (~free_bits + bfa_pkg::WORD_W'(1));

  assign result_o.hit     = |free_bits;
  assign result_o.bit_idx = bfa_pkg::onehot_to_idx(lowest);

endmodule

/* design/bitmap_free_allocator_unit.sv */
// Channel     | Signals                                          | Handshake
// ------------+--------------------------------------------------+---------------------------
// request     | kind_i, entry_index_i                            | start && !busy
// result      | found_index_o, found_o, entry_used_o, out_of_range_o | done_o, one cycle
// size reg    | cfg_wdata_i                                      | cfg_we_i
//
// Mark and test read the word, then write it back; out-of-range requests
// and find on an empty size answer straight from idle. Find scans words in turn,
// at most ceil(min(MAX_ENTRIES, 4096)/32) (128), one word per cycle through the read port.
// After reset a clearing pass writes every word (ceil(min(MAX_ENTRIES, 4096)/32),
// 128 at most) with busy high. The receiver cannot stall; results are strobes.
module bitmap_free_allocator_unit #(
  parameter int unsigned MAX_ENTRIES = bfa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [bfa_pkg::INDEX_W-1:0]   entry_index_i,
  input  logic                          cfg_we_i,
  input  logic [bfa_pkg::SIZE_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [bfa_pkg::INDEX_W-1:0]   found_index_o,
  output logic                          found_o,
  output logic                          entry_used_o,
  output logic                          out_of_range_o
);

  localparam int unsigned LIMIT  = (MAX_ENTRIES < bfa_pkg::INDEX_REACH) ?
                                   MAX_ENTRIES : bfa_pkg::INDEX_REACH;
  localparam int unsigned DEPTH  = (LIMIT + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } state_e;

  state_e                       state_q, state_d;
  logic [ADDR_W-1:0]            addr_q, addr_d;
  logic [bfa_pkg::INDEX_W-1:0]  idx_q, idx_d;
  bfa_pkg::kind_e               kind_q, kind_d;
  logic [bfa_pkg::SIZE_W-1:0]   cfg_q;

  logic                         done_q, done_d;
  logic [bfa_pkg::INDEX_W-1:0]  fidx_q, fidx_d;
  logic                         found_q, found_d;
  logic                         used_q, used_d;
  logic                         oor_q, oor_d;

  logic                         rd_en, wr_en;
  logic [ADDR_W-1:0]            rd_addr, wr_addr;
  logic [bfa_pkg::WORD_W-1:0]   rd_data, wr_data;

  logic [bfa_pkg::SIZE_W-1:0]   size_w;
  logic [bfa_pkg::SIZE_W-1:0]   base_w;
  logic                         last_word;
  logic                         new_bit;
  bfa_pkg::search_t             search;
  bfa_pkg::kind_e               kind_in;

  // Clip the managed size to the store
  assign size_w  = (cfg_q < bfa_pkg::SIZE_W'(LIMIT)) ? cfg_q : bfa_pkg::SIZE_W'(LIMIT);
  assign base_w  = bfa_pkg::SIZE_W'(addr_q) << bfa_pkg::BIT_W;
  assign last_word = ({1'b0, base_w} + (bfa_pkg::SIZE_W+1)'(bfa_pkg::WORD_W)) >=
                     {1'b0, size_w};
  assign kind_in = bfa_pkg::kind_e'(kind_i);

  bfa_bitmap_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  bfa_word_search u_search (
    .word_i   (rd_data),
    .base_i   (base_w),
    .size_i   (size_w),
    .result_o (search)
  );

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bfa_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Next state, memory access and result
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    idx_d   = idx_q;
    kind_d  = kind_q;
    done_d  = 1'b0;
    fidx_d  = fidx_q;
    found_d = 1'b0;
    used_d  = 1'b0;
    oor_d   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = rd_data;
    new_bit = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          idx_d  = entry_index_i;
          kind_d = kind_in;
          if (kind_in == bfa_pkg::KIND_FIND) begin
            if (size_w == '0) begin
              // Nothing managed: answer at once
              done_d = 1'b1;
              fidx_d = '0;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              addr_d  = '0;
              state_d = ST_SCAN;
            end
          end else if ({1'b0, entry_index_i} >= size_w) begin
            done_d = 1'b1;
            fidx_d = entry_index_i;
            oor_d  = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(entry_index_i >> bfa_pkg::BIT_W);
            addr_d  = ADDR_W'(entry_index_i >> bfa_pkg::BIT_W);
            state_d = ST_RMW;
          end
        end
      end

      ST_RMW: begin
        case (kind_q)
          bfa_pkg::KIND_MARK_USED: new_bit = 1'b1;
          bfa_pkg::KIND_MARK_FREE: new_bit = 1'b0;
          default:                 new_bit = rd_data[idx_q[bfa_pkg::BIT_W-1:0]];
        endcase
        wr_en   = 1'b1;
        wr_data[idx_q[bfa_pkg::BIT_W-1:0]] = new_bit;
        done_d  = 1'b1;
        fidx_d  = idx_q;
        used_d  = new_bit;
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        if (search.hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          fidx_d  = base_w[bfa_pkg::INDEX_W-1:0] |
                    bfa_pkg::INDEX_W'(search.bit_idx);
          state_d = ST_IDLE;
        end else if (last_word) begin
          done_d  = 1'b1;
          fidx_d  = '0;
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = addr_q + ADDR_W'(1);
          addr_d  = addr_q + ADDR_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      idx_q   <= '0;
      kind_q  <= bfa_pkg::KIND_MARK_USED;
      done_q  <= 1'b0;
      fidx_q  <= '0;
      found_q <= 1'b0;
      used_q  <= 1'b0;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      idx_q   <= idx_d;
      kind_q  <= kind_d;
      done_q  <= done_d;
      fidx_q  <= fidx_d;
      found_q <= found_d;
      used_q  <= used_d;
      oor_q   <= oor_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign found_index_o  = fidx_q;
  assign found_o        = found_q;
  assign entry_used_o   = used_q;
  assign out_of_range_o = oor_q;

  // Result strobes only once the unit is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Every accepted transaction either answers next cycle or keeps the unit busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted transaction dropped");

  // Writes only during the clearing pass or a read-modify-write
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_CLEAR || state_q == ST_RMW))
    else $error("memory write outside clear or update");

  // A find hit is never flagged out of range or as a used entry
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (!out_of_range_o && !entry_used_o))
    else $error("inconsistent find result");

  // An out-of-range request reports the entry as unused and not found
  a_oor_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_of_range_o |-> (!entry_used_o && !found_o))
    else $error("out-of-range result reports a used entry");

endmodule
